// ===== hdl/refcounted_page_allocator_assert.svh =====
// assertion macros for the page allocator checker
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RCPA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcpa assertion failed");

// next-cycle implication, disabled while in reset
`define RCPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcpa assertion failed");

`endif

// ===== hdl/rcpa_pkg.sv =====
// shared types and codes for the reference-counted page allocator
package rcpa_pkg;

	localparam int PAGE_IN_W = 14;
	localparam int REF_OUT_W = 8;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 1;

	localparam logic [2:0] OP_ALLOC     = 3'd0;
	localparam logic [2:0] OP_FREE      = 3'd1;
	localparam logic [2:0] OP_BOOT_FREE = 3'd2;
	localparam logic [2:0] OP_QUERY     = 3'd3;
	localparam logic [2:0] OP_INC       = 3'd4;
	localparam logic [2:0] OP_DEC       = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_RANGE     = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_USABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT   = 1'b1;

	localparam logic [CFG_W-1:0] FIRST_USABLE_RST = 15'd0;
	localparam logic [CFG_W-1:0] PAGE_LIMIT_RST   = 15'd16384;

	typedef struct packed {
		logic [2:0]           op;
		logic [PAGE_IN_W-1:0] page;
	} request_t;

	typedef struct packed {
		logic [PAGE_IN_W-1:0] alloc_page;
		logic [REF_OUT_W-1:0] ref_value;
		logic [2:0]           status;
	} result_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_sts_t;

endpackage

// ===== hdl/refcounted_page_allocator.sv =====
// top level of the reference-counted page allocator
// usage
//   request channel: drive start with a request (op, page); it is taken at a
//   clock edge where start is high and busy is low
//   result channel: done pulses for one cycle with alloc_page, ref_value and
//   status; the receiver must take it in that cycle, there is no back pressure
//   configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is always
//   high, write only while no request is outstanding
// timing
//   one request at a time, set by the single port of the count and link
//   memories: read at the accept edge, read-modify-write in the execute state
//   done is registered from the execute state, and the edge that takes the
//   result is also the first edge where the next request may be taken
// reset
//   the free list comes up empty; a sweep then zeroes every reference count,
//   one page per cycle with busy high; link entries are not cleared and
//   are only used for pages on the list
module refcounted_page_allocator import rcpa_pkg::*; #(
	parameter int NUM_PAGES  = 16384,
	parameter int COUNT_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  request_t             request,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	assign cfg_ready = 1'b1;

	rcpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rcpa_dp #(
		.NUM_PAGES  (NUM_PAGES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== hdl/rcpa_ctrl.sv =====
// controller: count-clearing sweep, request issue and execute sequencing
module rcpa_ctrl import rcpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd,
	output logic     busy
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.issue = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/rcpa_dp.sv =====
// datapath: free-list head, link and count memories, result register
module rcpa_dp import rcpa_pkg::*; #(
	parameter int NUM_PAGES  = 16384,
	parameter int COUNT_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	output dp_sts_t              sts,
	input  request_t             request,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 done,
	output result_t              result
);

	localparam int PAGE_W = $clog2(NUM_PAGES);
	localparam logic [31:0] NUM_PAGES_U = 32'(NUM_PAGES);
	localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [CFG_W-1:0] first_q;
	logic [CFG_W-1:0] limit_q;

	logic [PAGE_W-1:0] head_q;
	logic              head_valid_q;
	logic [PAGE_W-1:0] clr_q;

	logic [PAGE_W:0]       link_mem [NUM_PAGES];
	logic [COUNT_BITS-1:0] cnt_mem  [NUM_PAGES];

	logic [2:0]            op_s1;
	logic [PAGE_W-1:0]     addr_s1;
	logic                  in_mem_s1;
	logic                  usable_s1;
	logic [COUNT_BITS-1:0] cnt_rd_s1;
	logic [PAGE_W:0]       link_rd_s1;

	logic [PAGE_W-1:0]     addr_d;
	logic                  in_mem_d;
	logic                  usable_d;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  cnt_upd;
	logic                  push;
	logic                  pop;
	logic                  cnt_max;
	logic                  cnt_zero;
	result_t               res_d;

	logic                  cnt_we;
	logic [PAGE_W-1:0]     cnt_wa;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic                  link_we;

	logic                  done_q;
	result_t               res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_USABLE_RST;
			limit_q <= PAGE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIRST_USABLE: first_q <= cfg_data;
				REG_PAGE_LIMIT:   limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clearing sweep over the count memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_q == LAST_PAGE);

	// issue: address select and range checks
	assign addr_d   = (request.op == OP_ALLOC) ? head_q : PAGE_W'(request.page);
	assign in_mem_d = ({1'b0, request.page} < limit_q) && (32'(request.page) < NUM_PAGES_U);
	assign usable_d = !({1'b0, request.page} < first_q);

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			op_s1      <= request.op;
			addr_s1    <= addr_d;
			in_mem_s1  <= in_mem_d;
			usable_s1  <= usable_d;
			cnt_rd_s1  <= cnt_mem[addr_d];
			link_rd_s1 <= link_mem[addr_d];
		end
	end

	assign cnt_max  = (cnt_rd_s1 == CNT_MAX);
	assign cnt_zero = (cnt_rd_s1 == '0);

	// execute
	always_comb begin
		new_cnt = cnt_rd_s1;
		cnt_upd = 1'b0;
		push    = 1'b0;
		pop     = 1'b0;
		res_d   = '0;
		case (op_s1)
			OP_ALLOC: begin
				if (!head_valid_q) begin
					res_d.status = ST_EMPTY;
				end else begin
					pop = 1'b1;
					if (cnt_max) begin
						res_d.status = ST_OVERFLOW;
					end else begin
						new_cnt = cnt_rd_s1 + 1'b1;
						cnt_upd = 1'b1;
					end
					res_d.alloc_page = PAGE_IN_W'(addr_s1);
					res_d.ref_value  = REF_OUT_W'(new_cnt);
				end
			end
			OP_FREE, OP_BOOT_FREE: begin
				if (!in_mem_s1 || !usable_s1) begin
					res_d.status = ST_RANGE;
				end else if (op_s1 == OP_FREE && cnt_zero) begin
					res_d.status = ST_UNDERFLOW;
				end else begin
					if (op_s1 == OP_FREE) begin
						new_cnt = cnt_rd_s1 - 1'b1;
						cnt_upd = 1'b1;
					end
					push            = (new_cnt == '0);
					res_d.ref_value = REF_OUT_W'(new_cnt);
				end
			end
			OP_QUERY, OP_INC, OP_DEC: begin
				if (!in_mem_s1) begin
					res_d.status = ST_RANGE;
				end else begin
					if (op_s1 == OP_INC) begin
						if (cnt_max) begin
							res_d.status = ST_OVERFLOW;
						end else begin
							new_cnt = cnt_rd_s1 + 1'b1;
							cnt_upd = 1'b1;
						end
					end else if (op_s1 == OP_DEC) begin
						if (cnt_zero) begin
							res_d.status = ST_UNDERFLOW;
						end else begin
							new_cnt = cnt_rd_s1 - 1'b1;
							cnt_upd = 1'b1;
						end
					end
					res_d.ref_value = REF_OUT_W'(new_cnt);
				end
			end
			default: ;
		endcase
	end

	// memory writes
	assign cnt_we  = cmd.clear | (cmd.exec & cnt_upd);
	assign cnt_wa  = cmd.clear ? clr_q : addr_s1;
	assign cnt_wd  = cmd.clear ? '0 : new_cnt;
	assign link_we = cmd.exec & push;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (link_we) begin
			link_mem[addr_s1] <= {head_valid_q, head_q};
		end
	end

	// free-list head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			head_valid_q <= 1'b0;
		end else if (cmd.exec && pop) begin
			{head_valid_q, head_q} <= link_rd_s1;
		end else if (cmd.exec && push) begin
			head_q       <= addr_s1;
			head_valid_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== hdl/rcpa_check.sv =====
// port-level checker for the page allocator and its bind
`include "refcounted_page_allocator_assert.svh"

module rcpa_check import rcpa_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input result_t  result
);

	`RCPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`RCPA_ASSERT_IMPL(a_done_latency, done, $past(start && !busy, 2))
	`RCPA_ASSERT_IMPL(a_done_idle, done, !busy)
	`RCPA_ASSERT_IMPL(a_empty_zero, done && result.status == ST_EMPTY, result.alloc_page == '0 && result.ref_value == '0)

endmodule

bind refcounted_page_allocator rcpa_check u_rcpa_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);

// ===== sim/tb_refcounted_page_allocator.sv =====
// testbench for the reference-counted page allocator: directed and random requests checked against a local predictor
`timescale 1ns / 100ps

module tb_refcounted_page_allocator;
	import rcpa_pkg::*;

	localparam int NUM_PAGES = 16384;
	localparam logic [REF_OUT_W-1:0] COUNT_MAX = 8'hFF;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 70000;
	localparam int MAX_PRINTED = 100;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	request_t             request;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// predictor state
	logic [CFG_W-1:0]     first_usable = FIRST_USABLE_RST;
	logic [CFG_W-1:0]     page_limit = PAGE_LIMIT_RST;
	logic [PAGE_IN_W-1:0] head_page = '0;
	bit                   head_ok = 1'b0;
	bit [PAGE_IN_W-1:0]   link_page [NUM_PAGES];
	bit                   link_ok [NUM_PAGES];
	bit [REF_OUT_W-1:0]   count_mem [NUM_PAGES];
	int                   listed [NUM_PAGES];

	result_t              outstanding_results [$];
	logic [PAGE_IN_W-1:0] held_pages [$];
	int                   idle_pct = 0;
	int                   requests_taken = 0;
	int                   results_seen = 0;
	int                   cfg_writes = 0;
	int                   mismatches = 0;
	int                   status_tally [5];
	int                   quiet_cycles = 0;

	refcounted_page_allocator #(
		.NUM_PAGES(NUM_PAGES),
		.COUNT_BITS(REF_OUT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic request_t make_req(input logic [2:0] op, input logic [PAGE_IN_W-1:0] page);
		request_t r;
		r.op = op;
		r.page = page;
		return r;
	endfunction

	function automatic void push_free_page(input logic [PAGE_IN_W-1:0] p);
		link_page[p] = head_page;
		link_ok[p] = head_ok;
		head_page = p;
		head_ok = 1'b1;
		listed[p]++;
	endfunction

	function automatic result_t predict_page_op(input request_t req);
		result_t res;
		logic [PAGE_IN_W-1:0] p;
		bit in_mem;
		res = '0;
		p = req.page;
		in_mem = {1'b0, p} < page_limit;
		case (req.op)
		OP_ALLOC: begin
			if (!head_ok) begin
				res.status = ST_EMPTY;
			end else begin
				p = head_page;
				head_page = link_page[p];
				head_ok = link_ok[p];
				listed[p]--;
				if (count_mem[p] == COUNT_MAX)
					res.status = ST_OVERFLOW;
				else
					count_mem[p]++;
				res.alloc_page = p;
				res.ref_value = count_mem[p];
			end
		end
		OP_FREE, OP_BOOT_FREE: begin
			if (!in_mem || {1'b0, p} < first_usable) begin
				res.status = ST_RANGE;
			end else if (req.op == OP_FREE && count_mem[p] == 0) begin
				res.status = ST_UNDERFLOW;
			end else begin
				if (req.op == OP_FREE)
					count_mem[p]--;
				if (count_mem[p] == 0)
					push_free_page(p);
				res.ref_value = count_mem[p];
			end
		end
		OP_QUERY, OP_INC, OP_DEC: begin
			if (!in_mem) begin
				res.status = ST_RANGE;
			end else begin
				if (req.op == OP_INC) begin
					if (count_mem[p] == COUNT_MAX)
						res.status = ST_OVERFLOW;
					else
						count_mem[p]++;
				end else if (req.op == OP_DEC) begin
					if (count_mem[p] == 0)
						res.status = ST_UNDERFLOW;
					else
						count_mem[p]--;
				end
				res.ref_value = count_mem[p];
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int wanted);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, wanted);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (outstanding_results.size() == 0) begin
				report_mismatch("result with nothing outstanding, alloc_page",
					int'(result.alloc_page), 0);
			end else begin
				want = outstanding_results.pop_front();
				if (result.alloc_page !== want.alloc_page)
					report_mismatch("alloc_page", int'(result.alloc_page),
						int'(want.alloc_page));
				if (result.ref_value !== want.ref_value)
					report_mismatch("ref_value", int'(result.ref_value),
						int'(want.ref_value));
				if (result.status !== want.status)
					report_mismatch("status", int'(result.status), int'(want.status));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic sender_pause();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic issue_request(input request_t req);
		result_t want;
		start <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy) @(posedge clk);
		want = predict_page_op(req);
		outstanding_results.push_back(want);
		status_tally[want.status]++;
		requests_taken++;
		if (req.op == OP_ALLOC && want.status != ST_EMPTY && held_pages.size() < 256)
			held_pages.push_back(want.alloc_page);
		sender_pause();
	endtask

	task automatic settle();
		start <= 1'b0;
		while (outstanding_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_window(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] limit);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FIRST_USABLE;
		cfg_data <= first;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		first_usable = first;
		cfg_index <= REG_PAGE_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		page_limit = limit;
		cfg_valid <= 1'b0;
		cfg_writes += 2;
	endtask

	function automatic logic [PAGE_IN_W-1:0] find_idle_page(input logic [PAGE_IN_W-1:0] from);
		logic [PAGE_IN_W-1:0] p;
		p = from;
		while (count_mem[p] != 0 || listed[p] != 0)
			p++;
		return p;
	endfunction

	function automatic logic [PAGE_IN_W-1:0] pool_page();
		logic [CFG_W-1:0] base;
		base = (first_usable > 15'd16320) ? 15'd16320 : first_usable;
		return PAGE_IN_W'(base + $urandom_range(0, 63));
	endfunction

	function automatic logic [PAGE_IN_W-1:0] boundary_page();
		case ($urandom_range(3))
		0: return PAGE_IN_W'(first_usable - 1);
		1: return first_usable[PAGE_IN_W-1:0];
		2: return PAGE_IN_W'(page_limit - 1);
		default: return page_limit[PAGE_IN_W-1:0];
		endcase
	endfunction

	function automatic logic [PAGE_IN_W-1:0] held_or_pool();
		int idx;
		logic [PAGE_IN_W-1:0] p;
		if (held_pages.size() == 0 || $urandom_range(99) >= 80)
			return pool_page();
		idx = $urandom_range(held_pages.size() - 1);
		p = held_pages[idx];
		if (count_mem[p] == 0 || listed[p] != 0) begin
			held_pages.delete(idx);
			return pool_page();
		end
		return p;
	endfunction

	function automatic logic [2:0] known_op(input int k);
		case (k)
		0: return OP_ALLOC;
		1: return OP_FREE;
		2: return OP_BOOT_FREE;
		3: return OP_QUERY;
		4: return OP_INC;
		default: return OP_DEC;
		endcase
	endfunction

	// pages already on the free list are not pushed again until the final test
	function automatic request_t random_request();
		request_t req;
		int roll;
		roll = $urandom_range(99);
		if (roll < 28)
			req = make_req(OP_ALLOC, PAGE_IN_W'($urandom));
		else if (roll < 48)
			req = make_req(OP_FREE, held_or_pool());
		else if (roll < 58)
			req = make_req(OP_BOOT_FREE, ($urandom_range(99) < 30) ? held_or_pool() : pool_page());
		else if (roll < 66)
			req = make_req(OP_INC, held_or_pool());
		else if (roll < 74)
			req = make_req(OP_DEC, held_or_pool());
		else if (roll < 84)
			req = make_req(OP_QUERY, held_or_pool());
		else if (roll < 93)
			req = make_req(known_op($urandom_range(5)), PAGE_IN_W'($urandom));
		else if (roll < 96)
			req = make_req(($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7,
				PAGE_IN_W'($urandom));
		else
			req = make_req(($urandom_range(1) == 0) ? OP_FREE : OP_BOOT_FREE, boundary_page());
		if ((req.op == OP_FREE || req.op == OP_BOOT_FREE || req.op == OP_INC)
				&& listed[req.page] != 0)
			req.op = OP_QUERY;
		return req;
	endfunction

	task automatic test_empty_and_unknown();
		idle_pct = 0;
		issue_request(make_req(OP_ALLOC, 14'h3FFF));
		issue_request(make_req(OP_QUERY, 14'd0));
		issue_request(make_req(OP_QUERY, 14'h3FFF));
		issue_request(make_req(OP_DEC, 14'd0));
		issue_request(make_req(OP_FREE, 14'd0));
		issue_request(make_req(OP_SPARE_6, 14'h3FFF));
		issue_request(make_req(OP_SPARE_7, 14'h2AAA));
	endtask

	task automatic test_range_limits();
		settle();
		idle_pct = 63;
		program_window(15'd16383, PAGE_LIMIT_RST);
		issue_request(make_req(OP_BOOT_FREE, 14'd16382));
		issue_request(make_req(OP_BOOT_FREE, 14'd16383));
		issue_request(make_req(OP_ALLOC, 14'd0));
		issue_request(make_req(OP_FREE, 14'd16383));
		issue_request(make_req(OP_ALLOC, 14'd0));
		issue_request(make_req(OP_BOOT_FREE, 14'd16383));
		issue_request(make_req(OP_FREE, 14'd16383));
		settle();
		program_window(15'd16, 15'd0);
		issue_request(make_req(OP_QUERY, 14'd5));
		issue_request(make_req(OP_BOOT_FREE, 14'd16));
		issue_request(make_req(OP_ALLOC, 14'd0));
		settle();
		program_window(15'd16, 15'd100);
		issue_request(make_req(OP_QUERY, 14'd99));
		issue_request(make_req(OP_INC, 14'd100));
		issue_request(make_req(OP_INC, 14'd15));
		issue_request(make_req(OP_DEC, 14'd15));
		issue_request(make_req(OP_DEC, 14'd15));
		issue_request(make_req(OP_BOOT_FREE, 14'd15));
		issue_request(make_req(OP_FREE, 14'd100));
		issue_request(make_req(OP_BOOT_FREE, 14'd99));
		issue_request(make_req(OP_ALLOC, 14'd0));
	endtask

	// counts pinned at the top, then handed out by allocate
	task automatic test_count_saturation();
		logic [PAGE_IN_W-1:0] p;
		settle();
		program_window(FIRST_USABLE_RST, PAGE_LIMIT_RST);
		idle_pct = 22;
		p = find_idle_page(14'd12000);
		issue_request(make_req(OP_BOOT_FREE, p));
		repeat (256) issue_request(make_req(OP_INC, p));
		issue_request(make_req(OP_ALLOC, 14'd0));
		issue_request(make_req(OP_FREE, p));
		issue_request(make_req(OP_QUERY, p));
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] lo;
		for (int round = 0; round < 6; round++) begin
			settle();
			case (round)
			0: program_window(FIRST_USABLE_RST, PAGE_LIMIT_RST);
			1: program_window(15'd64, 15'd8192);
			2: program_window(15'd1000, 15'd1064);
			3: begin
				lo = CFG_W'($urandom_range(0, 16000));
				program_window(lo, lo + CFG_W'($urandom_range(1, 384)));
			end
			4: program_window(15'd16384, 15'd16384);
			default: program_window(FIRST_USABLE_RST, PAGE_LIMIT_RST);
			endcase
			case (round % 3)
			0: idle_pct = 0;
			1: idle_pct = 63;
			default: idle_pct = 22;
			endcase
			repeat (140) issue_request(random_request());
		end
	endtask

	// pushing a page twice links it to itself, so allocate keeps returning it
	task automatic test_repeated_push();
		logic [PAGE_IN_W-1:0] p;
		settle();
		program_window(FIRST_USABLE_RST, PAGE_LIMIT_RST);
		idle_pct = 0;
		p = find_idle_page(14'd8000);
		issue_request(make_req(OP_BOOT_FREE, p));
		issue_request(make_req(OP_BOOT_FREE, p));
		repeat (3) issue_request(make_req(OP_ALLOC, 14'd0));
	endtask

	initial begin
		start <= 1'b0;
		request <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_unknown();
		test_range_limits();
		test_count_saturation();
		test_random_traffic();
		test_repeated_push();
		settle();
		$display("covered %0d requests, %0d results, %0d register writes",
			requests_taken, results_seen, cfg_writes);
		$display("statuses: ok %0d, empty %0d, range %0d, underflow %0d, overflow %0d",
			status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_RANGE],
			status_tally[ST_UNDERFLOW], status_tally[ST_OVERFLOW]);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== refcounted_page_allocator.f =====
+incdir+hdl
hdl/rcpa_pkg.sv
hdl/rcpa_ctrl.sv
hdl/rcpa_dp.sv
hdl/refcounted_page_allocator.sv
hdl/rcpa_check.sv
sim/tb_refcounted_page_allocator.sv
